// ===== hdl/qfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// qfpr_pkg
// Shared types and codes of the false-position root finder.
// ----------------------------------------------------------------------------
package qfpr_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int TOL_BITS     = 31;
  localparam int LIM_BITS     = 8;
  localparam int PASS_BITS    = 9;
  localparam int STAT_BITS    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_SQUARE = 3'd0,
    CFG_COEF_LINEAR = 3'd1,
    CFG_COEF_CONST  = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_MAX_ITER    = 3'd4
  } cfg_idx_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_FOUND = 2'd0,
    ST_LIMIT = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_M_SQ, OP_S_SQ, OP_M_P1, OP_S_P1, OP_M_P2, OP_S_P2,
    OP_SUM, OP_FIN, OP_ST_F1, OP_ST_F2, OP_BRK, OP_SEC, OP_DINIT, OP_DSTEP,
    OP_X3, OP_UPD, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    PH_F1 = 2'd0,
    PH_F2 = 2'd1,
    PH_F3 = 2'd2
  } phase_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;       // bracket rejected
    logic more;      // another pass is due
    logic div_done;  // divider finished
    logic out_busy;  // result register full
  } dp_stat_t;

endpackage

// ===== hdl/qfpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfpr_ctrl
// Sequencer: evaluations, bracket check, secant passes and result hand-off.
// ----------------------------------------------------------------------------
module qfpr_ctrl
  import qfpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     idle,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_M_SQ  = 20'h00002,
    S_S_SQ  = 20'h00004,
    S_M_P1  = 20'h00008,
    S_S_P1  = 20'h00010,
    S_M_P2  = 20'h00020,
    S_S_P2  = 20'h00040,
    S_SUM   = 20'h00080,
    S_FIN   = 20'h00100,
    S_ST_F1 = 20'h00200,
    S_ST_F2 = 20'h00400,
    S_BRK   = 20'h00800,
    S_SEC   = 20'h01000,
    S_DINIT = 20'h02000,
    S_DSTEP = 20'h04000,
    S_X3    = 20'h08000,
    S_UPD   = 20'h10000,
    S_LOOP  = 20'h20000,
    S_DONE  = 20'h40000,
    S_BAD   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          phase_nxt = PH_F1;
          state_nxt = S_M_SQ;
        end
      end
      S_M_SQ: begin cmd.op = OP_M_SQ; state_nxt = S_S_SQ; end
      S_S_SQ: begin cmd.op = OP_S_SQ; state_nxt = S_M_P1; end
      S_M_P1: begin cmd.op = OP_M_P1; state_nxt = S_S_P1; end
      S_S_P1: begin cmd.op = OP_S_P1; state_nxt = S_M_P2; end
      S_M_P2: begin cmd.op = OP_M_P2; state_nxt = S_S_P2; end
      S_S_P2: begin cmd.op = OP_S_P2; state_nxt = S_SUM; end
      S_SUM:  begin cmd.op = OP_SUM;  state_nxt = S_FIN; end
      S_FIN: begin
        cmd.op = OP_FIN;
        case (phase_r)
          PH_F1:   state_nxt = S_ST_F1;
          PH_F2:   state_nxt = S_ST_F2;
          default: state_nxt = S_UPD;
        endcase
      end
      S_ST_F1: begin
        cmd.op    = OP_ST_F1;
        phase_nxt = PH_F2;
        state_nxt = S_M_SQ;
      end
      S_ST_F2: begin cmd.op = OP_ST_F2; state_nxt = S_BRK; end
      S_BRK: begin
        cmd.op    = OP_BRK;
        state_nxt = S_LOOP;
      end
      S_SEC:   begin cmd.op = OP_SEC;   state_nxt = S_DINIT; end
      S_DINIT: begin cmd.op = OP_DINIT; state_nxt = S_DSTEP; end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (stat.div_done) begin
          cmd.op    = OP_NOP;
          state_nxt = S_X3;
        end
      end
      S_X3: begin
        cmd.op    = OP_X3;
        phase_nxt = PH_F3;
        state_nxt = S_M_SQ;
      end
      S_UPD: begin cmd.op = OP_UPD; state_nxt = S_LOOP; end
      S_LOOP: begin
        // status flags are registered by BRK / UPD the cycle before
        if (stat.bad)       state_nxt = S_BAD;
        else if (stat.more) state_nxt = S_SEC;
        else                state_nxt = S_DONE;
      end
      S_DONE, S_BAD: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_F1;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hdl/qfpr_dp.sv =====
// ----------------------------------------------------------------------------
// qfpr_dp
// Datapath: registers, shared multiplier, restoring divider, result register.
// ----------------------------------------------------------------------------
module qfpr_dp
  import qfpr_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16,
  parameter int CW = 32
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [W-1:0]         in_low,
  input  logic [W-1:0]         in_high,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [W-1:0]         out_root,
  output logic [STAT_BITS-1:0] out_status,
  output logic [PASS_BITS-1:0] out_passes
);

  localparam int PW  = 2*W + 2;
  localparam int NB  = $clog2(PW + 1);
  localparam int TW  = W + TOL_BITS + 1;
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W-1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);
  localparam logic [W-1:0]  WMAX    = LIM_POS[W-1:0];
  localparam logic [W-1:0]  WMIN    = LIM_NEG[W-1:0];

  function automatic logic [W:0] magw(input logic [W:0] v);
    return v[W] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] fsat(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] s;
    logic [PW-1:0] r;
    s = p >> F;
    r = neg ? ((s > LIM_NEG) ? LIM_NEG : s) : ((s > LIM_POS) ? LIM_POS : s);
    return neg ? W'(~r + 1'b1) : W'(r);
  endfunction

  function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W:0] sx(input logic [W-1:0] v);
    return {v[W-1], v};
  endfunction

  // configuration
  logic [W-1:0]          c2_r, c1_r, c0_r;
  logic [TOL_BITS-1:0]   tol_r;
  logic [LIM_BITS-1:0]   lim_r;

  // working registers
  logic [W-1:0]  x1_r, x2_r, xe_r, f1_r, f2_r, fe_r, sq_r, p1_r, p2_r, acc_r;
  logic [PW-1:0] prod_r;
  logic          neg_r, sneg_r, triv_r;
  logic [W:0]    den_r, rem_r;
  logic [PW-1:0] dq_r;
  logic [NB-1:0] dcnt_r;
  logic [PASS_BITS-1:0] cnt_r;
  logic          found_r, bad_r;

  logic          ov_r;
  logic [W-1:0]  oroot_r;
  logic [STAT_BITS-1:0] ostat_r;
  logic [PASS_BITS-1:0] opass_r;

  // shared multiplier operands
  logic [W:0]    ma, mb;
  logic [PW-1:0] prod;
  logic [W:0]    dx, den, f3m;
  logic [W+1:0]  trial;
  logic          ge;
  logic [W:0]    xsum;
  logic          f1pos, f1neg, f2pos, f2neg, f3pos, f3neg;

  always_comb begin
    ma = magw(sx(xe_r));
    mb = magw(sx(xe_r));
    case (cmd.op)
      OP_M_P1: begin ma = magw(sx(c2_r)); mb = magw(sx(sq_r)); end
      OP_M_P2: begin ma = magw(sx(c1_r)); mb = magw(sx(xe_r)); end
      OP_SEC:  begin ma = magw(dx);       mb = magw(sx(f1_r)); end
      default: ;
    endcase
  end

  assign prod  = PW'(ma) * PW'(mb);
  assign dx    = sx(x2_r) - sx(x1_r);
  assign den   = sx(f1_r) - sx(f2_r);
  assign trial = {rem_r, dq_r[PW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign xsum  = sneg_r ? (sx(x1_r) - dq_r[W:0]) : (sx(x1_r) + dq_r[W:0]);
  assign f3m   = magw(sx(fe_r));

  assign f1pos = !f1_r[W-1] && (f1_r != '0);
  assign f1neg = f1_r[W-1];
  assign f2pos = !f2_r[W-1] && (f2_r != '0);
  assign f2neg = f2_r[W-1];
  assign f3pos = !fe_r[W-1] && (fe_r != '0);
  assign f3neg = fe_r[W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r    <= '0;
      c1_r    <= '0;
      c0_r    <= '0;
      tol_r   <= TOL_BITS'(66);
      lim_r   <= LIM_BITS'(100);
      ov_r    <= 1'b0;
      bad_r   <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
      dcnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_SQUARE: c2_r  <= cfg_wdata[W-1:0];
          CFG_COEF_LINEAR: c1_r  <= cfg_wdata[W-1:0];
          CFG_COEF_CONST:  c0_r  <= cfg_wdata[W-1:0];
          CFG_TOLERANCE:   tol_r <= cfg_wdata[TOL_BITS-1:0];
          CFG_MAX_ITER:    lim_r <= cfg_wdata[LIM_BITS-1:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          x1_r    <= in_low;
          x2_r    <= in_high;
          xe_r    <= in_low;
          cnt_r   <= '0;
          found_r <= 1'b0;
          bad_r   <= 1'b0;
        end
        OP_M_SQ: begin prod_r <= prod; neg_r <= 1'b0; end
        OP_S_SQ: sq_r <= fsat(prod_r, neg_r);
        OP_M_P1: begin prod_r <= prod; neg_r <= c2_r[W-1] ^ sq_r[W-1]; end
        OP_S_P1: p1_r <= fsat(prod_r, neg_r);
        OP_M_P2: begin prod_r <= prod; neg_r <= c1_r[W-1] ^ xe_r[W-1]; end
        OP_S_P2: p2_r <= fsat(prod_r, neg_r);
        OP_SUM:  acc_r <= sadd(p1_r, p2_r);
        OP_FIN:  fe_r <= sadd(acc_r, c0_r);
        OP_ST_F1: begin f1_r <= fe_r; xe_r <= x2_r; end
        OP_ST_F2: f2_r <= fe_r;
        OP_BRK:  bad_r <= (f1pos && f2pos) || (f1neg && f2neg);
        OP_SEC: begin
          prod_r <= prod;
          den_r  <= magw(den);
          sneg_r <= dx[W] ^ f1_r[W-1] ^ den[W];
          triv_r <= (den == '0) || (f1_r == '0) || (dx == '0);
        end
        OP_DINIT: begin
          dq_r   <= prod_r;
          rem_r  <= '0;
          dcnt_r <= '0;
        end
        OP_DSTEP: begin
          rem_r  <= ge ? (W+1)'(trial - {1'b0, den_r}) : trial[W:0];
          dq_r   <= {dq_r[PW-2:0], ge};
          dcnt_r <= dcnt_r + 1'b1;
        end
        OP_X3: xe_r <= triv_r ? x1_r : xsum[W-1:0];
        OP_UPD: begin
          if ((!f1pos && !f3pos) || (!f1neg && !f3neg)) begin
            x1_r <= xe_r;
            f1_r <= fe_r;
          end else begin
            x2_r <= xe_r;
            f2_r <= fe_r;
          end
          cnt_r   <= cnt_r + 1'b1;
          found_r <= (fe_r == '0) || (TW'(f3m) < TW'(tol_r));
        end
        OP_OUT: begin
          ov_r    <= 1'b1;
          oroot_r <= bad_r ? '0 : xe_r;
          ostat_r <= bad_r ? ST_BAD : (found_r ? ST_FOUND : ST_LIMIT);
          opass_r <= bad_r ? '0 : cnt_r;
        end
        default: ;
      endcase
    end
  end

  assign stat.bad      = bad_r;
  assign stat.more     = !found_r && (cnt_r <= {1'b0, lim_r});
  assign stat.div_done = (dcnt_r == NB'(PW));
  assign stat.out_busy = ov_r;

  assign out_valid  = ov_r;
  assign out_root   = oroot_r;
  assign out_status = ostat_r;
  assign out_passes = opass_r;

endmodule

// ===== hdl/quadratic_false_position_root_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_false_position_root_unit
// Regula falsi root search of c2*x^2 + c1*x + c0 in saturating fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, lowest bit up)
//  in_     | in  | bracket_low, bracket_high
//  out_    | out | root_estimate, status, passes_used
//  cfg_    | in  | write enable, register index, data
//
//  One f evaluation runs x*x, c2*x^2 and c1*x on the shared multiplier,
//  then adds the terms and c0; each pass evaluates f at the point that
//  the bit-serial restoring divider's quotient places on the secant.
//  rst_n is synchronous; the result register holds until out_tready, and a
//  new beat is taken only once the previous result is in that register.
// ----------------------------------------------------------------------------
module quadratic_false_position_root_unit
  import qfpr_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
)(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // bracket_low, bracket_high
  input  logic [((2*WORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // root_estimate, status, passes_used
  output logic [((WORD_BITS+STAT_BITS+PASS_BITS+7)/8)*8-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [((WORD_BITS > TOL_BITS) ? WORD_BITS : TOL_BITS)-1:0] cfg_wdata
);

  localparam int CW = (WORD_BITS > TOL_BITS) ? WORD_BITS : TOL_BITS;
  localparam int OB = ((WORD_BITS+STAT_BITS+PASS_BITS+7)/8)*8;
  localparam int OF = WORD_BITS+STAT_BITS+PASS_BITS;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;
  logic [WORD_BITS-1:0] root;
  logic [STAT_BITS-1:0] status;
  logic [PASS_BITS-1:0] passes;

  assign in_tready = idle;

  qfpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_tvalid),
    .idle  (idle),
    .stat  (stat),
    .cmd   (cmd)
  );

  qfpr_dp #(.W(WORD_BITS), .F(FRAC_BITS), .CW(CW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_low     (in_tdata[WORD_BITS-1:0]),
    .in_high    (in_tdata[2*WORD_BITS-1:WORD_BITS]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_root   (root),
    .out_status (status),
    .out_passes (passes)
  );

  assign out_tdata = {{(OB-OF){1'b0}}, passes, status, root};

`ifndef SYNTHESIS
  // a rejected bracket reports no root and no passes
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_BAD |-> root == '0 && passes == '0)
    else $error("bad bracket result not clean");
  // every non-rejected result ran at least one pass
  a_pass_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != ST_BAD |-> passes != '0)
    else $error("result without a pass");
  // no beat is taken while an item is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");
`endif

endmodule
